/* sv/first_fit_block_allocator_assert.svh */
// Assertion macros used by the checker of the allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ffba_pkg.sv */
package ffba_pkg;

    // Default sizes of the two tables
    localparam int BLOCKS_DEF    = 16;
    localparam int OWNER_IDS_DEF = 256;

    // Field widths
    localparam int SIZE_W       = 16;
    localparam int ID_W         = 8;
    localparam int ACT_W        = 2;
    localparam int ST_W         = 3;
    localparam int BIDX_W       = 4;
    localparam int IN_TDATA_W   = SIZE_W + ID_W;
    localparam int OUT_FIELDS_W = BIDX_W + 2 * SIZE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD     = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_NOTLIVE = 3'd2,
        ST_FULL    = 3'd3,
        ST_LIVE    = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [BIDX_W-1:0]   blk;
        logic [SIZE_W-1:0]   amount;
        logic [SIZE_W-1:0]   free_left;
    } t_result;

    // Owner table update strobes
    typedef struct packed {
        logic set;
        logic clr;
    } t_own_ctl;

endpackage

/* sv/ffba_owner_table.sv */
module ffba_owner_table #(
    parameter int IDS     = 256,
    parameter int BLOCK_W = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(IDS)-1:0]        i_id,
    input  ffba_pkg::t_own_ctl            i_ctl,
    input  logic [BLOCK_W-1:0]            i_blk,
    input  logic [ffba_pkg::SIZE_W-1:0]   i_size,
    output logic                          o_live,
    output logic [BLOCK_W-1:0]            o_blk,
    output logic [ffba_pkg::SIZE_W-1:0]   o_size
);
    import ffba_pkg::*;

    localparam int ENT_W = BLOCK_W + SIZE_W;

    logic [IDS-1:0]   r_live;
    logic [ENT_W-1:0] r_mem [IDS];
    logic [ENT_W-1:0] r_rdata;

    // Live bits: cleared at reset, set on allocate, cleared on release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_ctl.set) begin
            r_live[i_id] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_live[i_id] <= 1'b0;
        end
    end

    // Block and size store, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_mem[i_id] <= {i_blk, i_size};
        end
        r_rdata <= r_mem[i_id];
    end

    assign o_live = r_live[i_id];
    assign o_blk  = r_rdata[ENT_W-1:SIZE_W];
    assign o_size = r_rdata[SIZE_W-1:0];

endmodule

/* sv/first_fit_block_allocator.sv */
// First-fit block allocator. Each request on the slave stream (tuser = action) adds a block,
// allocates space for an owner id from the lowest-indexed block that has room, or releases
// an owner's space back to its block, and yields exactly one result on the master stream
// (tuser = status). The block takes one request at a time, and for an allocate a single
// add/subtract-compare unit walks the free-space memory one entry per cycle. A result waits
// in the output register until it is taken; the next request can be accepted meanwhile but
// does not finish before that.
// Owner live bits clear at reset; block free-space entries are valid once their block is added.
module first_fit_block_allocator #(
    parameter int BLOCKS    = ffba_pkg::BLOCKS_DEF,
    parameter int OWNER_IDS = ffba_pkg::OWNER_IDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request_size [15:0], owner_id [23:16]
    input  logic [ffba_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // action [1:0]
    input  logic [ffba_pkg::ACT_W-1:0]         i_s_axis_tuser,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // block_index [3:0], amount [19:4], free_left [35:20], zero fill above
    output logic [ffba_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // status [2:0]
    output logic [ffba_pkg::ST_W-1:0]          o_m_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready
);
    import ffba_pkg::*;

    localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = BW + 1;
    localparam int IW = $clog2(OWNER_IDS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_OWN    = 6'b001000,
        S_REL    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_action             r_act;
    logic [SIZE_W-1:0]   r_req;
    logic [ID_W-1:0]     r_id;
    logic [CW-1:0]       r_count, n_count;
    logic [BW-1:0]       r_idx, n_idx;
    t_result             r_res, n_res;
    t_result             r_out;
    logic                r_out_valid;

    logic [SIZE_W-1:0]   r_fs_mem [BLOCKS];
    logic [SIZE_W-1:0]   r_fs_q;
    logic [BW-1:0]       w_fs_raddr;
    logic                w_fs_we;
    logic [BW-1:0]       w_fs_waddr;
    logic [SIZE_W-1:0]   w_fs_wdata;

    logic                w_sub;
    logic [SIZE_W-1:0]   w_opb;
    logic [SIZE_W:0]     w_sum;
    logic                w_fits;

    t_own_ctl            w_own_ctl;
    logic                w_live;
    logic [BW-1:0]       w_own_blk;
    logic [SIZE_W-1:0]   w_own_size;

    logic                w_accept;
    logic                w_id_ok;
    logic [CW-1:0]       w_idx_next;

    function automatic logic [BIDX_W-1:0] to_bidx(input logic [BW-1:0] v);
        logic [BW+BIDX_W-1:0] e;
        e = {{BIDX_W{1'b0}}, v};
        return e[BIDX_W-1:0];
    endfunction

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_id_ok    = ({1'b0, r_id} < (ID_W + 1)'(OWNER_IDS));
    assign w_idx_next = {{(CW - BW){1'b0}}, r_idx} + CW'(1);

    // Shared add/subtract unit: compares and updates free space
    assign w_sub  = (r_state == S_SCAN);
    assign w_opb  = w_sub ? ~r_req : w_own_size;
    assign w_sum  = {1'b0, r_fs_q} + {1'b0, w_opb} + (SIZE_W + 1)'(w_sub);
    assign w_fits = w_sum[SIZE_W];

    ffba_owner_table #(
        .IDS     (OWNER_IDS),
        .BLOCK_W (BW)
    ) u_owner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_id    (r_id[IW-1:0]),
        .i_ctl   (w_own_ctl),
        .i_blk   (r_idx),
        .i_size  (r_req),
        .o_live  (w_live),
        .o_blk   (w_own_blk),
        .o_size  (w_own_size)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_res      = r_res;
        w_fs_we    = 1'b0;
        w_fs_waddr = r_idx;
        w_fs_wdata = w_sum[SIZE_W-1:0];
        w_fs_raddr = r_idx;
        w_own_ctl  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res   = '{status: ST_OK, blk: '0, amount: '0, free_left: '0};
                n_state = S_DONE;
                n_idx   = '0;
                w_fs_raddr = '0;
                case (r_act)
                    ACT_ADD: begin
                        if (r_count >= CW'(BLOCKS)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            w_fs_we    = 1'b1;
                            w_fs_waddr = r_count[BW-1:0];
                            w_fs_wdata = r_req;
                            n_count    = r_count + CW'(1);
                            n_res      = '{status: ST_OK, blk: to_bidx(r_count[BW-1:0]),
                                           amount: r_req, free_left: r_req};
                        end
                    end
                    ACT_ALLOC: begin
                        if (!w_id_ok) begin
                            n_res.status = ST_NOTLIVE;
                        end else if (w_live) begin
                            n_res.status = ST_LIVE;
                        end else if (r_count == '0) begin
                            n_res.status = ST_NOFIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    ACT_RELEASE: begin
                        if (!w_id_ok || !w_live) begin
                            n_res.status = ST_NOTLIVE;
                        end else begin
                            n_state = S_OWN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                w_fs_raddr = w_idx_next[BW-1:0];
                if (w_fits) begin
                    w_fs_we       = 1'b1;
                    w_own_ctl.set = 1'b1;
                    n_res   = '{status: ST_OK, blk: to_bidx(r_idx),
                                amount: r_req, free_left: w_sum[SIZE_W-1:0]};
                    n_state = S_DONE;
                end else if (w_idx_next >= r_count) begin
                    n_res.status = ST_NOFIT;
                    n_state      = S_DONE;
                end else begin
                    n_idx = w_idx_next[BW-1:0];
                end
            end
            S_OWN: begin
                w_fs_raddr = w_own_blk;
                n_state    = S_REL;
            end
            S_REL: begin
                w_fs_we       = 1'b1;
                w_fs_waddr    = w_own_blk;
                w_own_ctl.clr = 1'b1;
                n_res   = '{status: ST_OK, blk: to_bidx(w_own_blk),
                            amount: w_own_size, free_left: w_sum[SIZE_W-1:0]};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Request capture and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= t_action'(i_s_axis_tuser);
            r_req <= i_s_axis_tdata[SIZE_W-1:0];
            r_id  <= i_s_axis_tdata[IN_TDATA_W-1:SIZE_W];
        end
        r_idx <= n_idx;
        r_res <= n_res;
    end

    // Free-space memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_fs_we) begin
            r_fs_mem[w_fs_waddr] <= w_fs_wdata;
        end
        r_fs_q <= r_fs_mem[w_fs_raddr];
    end

    // Output register: load when the slot frees up, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                              r_out.free_left, r_out.amount, r_out.blk};

endmodule

/* sv/ffba_checker.sv */
module ffba_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [ffba_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  logic [ffba_pkg::ST_W-1:0]          i_m_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready
);
    import ffba_pkg::*;

`include "first_fit_block_allocator_assert.svh"

    // Hold a stalled result
    `FFBA_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser),
        "stalled result changed or vanished")

    // Busy right after taking a request
    `FFBA_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && i_s_tready, !i_s_tready,
        "request accepted while previous one in progress")

    // Failed requests report zero fields
    `FFBA_ASSERT_NOW(a_fail_zero, i_m_tvalid && (i_m_tuser != ST_OK), i_m_tdata == '0,
        "failure result carries nonzero fields")

    // Status stays within defined codes
    `FFBA_ASSERT_NOW(a_status_code, i_m_tvalid,
        (i_m_tuser == ST_OK) || (i_m_tuser == ST_NOFIT) || (i_m_tuser == ST_NOTLIVE) ||
        (i_m_tuser == ST_FULL) || (i_m_tuser == ST_LIVE),
        "undefined status code")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready)
);

/* sim/allocation_checker.sv */
`timescale 1ns / 100ps

module allocation_checker #(
    parameter int BLOCKS    = ffba_pkg::BLOCKS_DEF,
    parameter int OWNER_IDS = ffba_pkg::OWNER_IDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request_size [15:0], owner_id [23:16]
    input  logic [ffba_pkg::IN_TDATA_W-1:0]  i_req_tdata,
    // action [1:0]
    input  logic [ffba_pkg::ACT_W-1:0]       i_req_tuser,
    input  logic                             i_req_tvalid,
    input  logic                             i_req_tready,
    // block_index [3:0], amount [19:4], free_left [35:20], zero fill above
    input  logic [ffba_pkg::OUT_TDATA_W-1:0] i_res_tdata,
    // status [2:0]
    input  logic [ffba_pkg::ST_W-1:0]        i_res_tuser,
    input  logic                             i_res_tvalid,
    input  logic                             i_res_tready,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ffba_pkg::*;

    typedef struct {
        logic              live;
        int                blk;
        logic [SIZE_W-1:0] held;
    } t_owner_entry;

    // Tracked allocator state
    logic [SIZE_W-1:0] blk_room [BLOCKS];
    int                blocks_added;
    t_owner_entry      owners [OWNER_IDS];

    // Results still owed by the block, oldest first
    t_result           outcomes_due [$];
    t_result           got_result;
    t_result           want_result;

    // Apply one request to the tracked state and return the result it must produce
    function automatic t_result first_fit_outcome(input t_action act,
            input logic [SIZE_W-1:0] amt, input logic [ID_W-1:0] id);
        t_result r;
        int      b;
        // all-zero is status ok with empty fields, also the answer to a no-op
        r = '0;
        case (act)
            ACT_ADD: begin
                if (blocks_added >= BLOCKS) begin
                    r.status = ST_FULL;
                end else begin
                    blk_room[blocks_added] = amt;
                    r.blk       = BIDX_W'(blocks_added);
                    r.amount    = amt;
                    r.free_left = amt;
                    blocks_added++;
                end
            end
            ACT_ALLOC: begin
                if (int'(id) >= OWNER_IDS) begin
                    r.status = ST_NOTLIVE;
                end else if (owners[id].live) begin
                    r.status = ST_LIVE;
                end else begin
                    // take the lowest block with enough room
                    b = 0;
                    while (b < blocks_added && blk_room[b] < amt)
                        b++;
                    if (b >= blocks_added) begin
                        r.status = ST_NOFIT;
                    end else begin
                        blk_room[b] = blk_room[b] - amt;
                        owners[id]  = '{live: 1'b1, blk: b, held: amt};
                        r.blk       = BIDX_W'(b);
                        r.amount    = amt;
                        r.free_left = blk_room[b];
                    end
                end
            end
            ACT_RELEASE: begin
                if (int'(id) >= OWNER_IDS || !owners[id].live) begin
                    r.status = ST_NOTLIVE;
                end else begin
                    // give the owner's space back to the block it came from
                    b           = owners[id].blk;
                    blk_room[b] = blk_room[b] + owners[id].held;
                    r.blk       = BIDX_W'(b);
                    r.amount    = owners[id].held;
                    r.free_left = blk_room[b];
                    owners[id]  = '{live: 1'b0, blk: 0, held: '0};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
            input logic [SIZE_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blocks_added = 0;
            foreach (owners[i])
                owners[i] = '{live: 1'b0, blk: 0, held: '0};
            outcomes_due.delete();
            o_fail_count = 0;
        end else begin
            // retire the oldest expected result
            if (i_res_tvalid && i_res_tready) begin
                got_result = {i_res_tuser, i_res_tdata[BIDX_W-1:0],
                              i_res_tdata[BIDX_W +: SIZE_W],
                              i_res_tdata[BIDX_W + SIZE_W +: SIZE_W]};
                if (outcomes_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: extra result: expected none, got %0d %0d %0d %0d",
                             $time, got_result.status, got_result.blk, got_result.amount,
                             got_result.free_left);
                end else begin
                    want_result = outcomes_due.pop_front();
                    check_field("status", SIZE_W'(want_result.status),
                                SIZE_W'(got_result.status));
                    check_field("block_index", SIZE_W'(want_result.blk),
                                SIZE_W'(got_result.blk));
                    check_field("amount", want_result.amount, got_result.amount);
                    check_field("free_left", want_result.free_left, got_result.free_left);
                end
            end
            // predict the result of each accepted request
            if (i_req_tvalid && i_req_tready)
                outcomes_due.insert(outcomes_due.size(),
                                    first_fit_outcome(t_action'(i_req_tuser),
                                                      i_req_tdata[SIZE_W-1:0],
                                                      i_req_tdata[SIZE_W +: ID_W]));
        end
        o_pending = outcomes_due.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import ffba_pkg::*;

    localparam int BLOCKS          = BLOCKS_DEF;
    localparam int OWNER_IDS       = OWNER_IDS_DEF;
    localparam int RANDOM_REQUESTS = 1420;
    localparam int QUIET_TAIL      = 150;
    localparam int ID_POOL         = 24;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AT     = 300;
    localparam int DRAIN_CYCLES    = BLOCKS + 16;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]       s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]        m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    int                     fail_count;
    int                     pending;

    // Shared pacing knobs: chance of an idle burst, and the one-time long hold-off
    int                     idle_pct     = 15;
    logic                   hold_off_req = 1'b0;

    first_fit_block_allocator #(
        .BLOCKS    (BLOCKS),
        .OWNER_IDS (OWNER_IDS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    allocation_checker #(
        .BLOCKS    (BLOCKS),
        .OWNER_IDS (OWNER_IDS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_tdata  (s_tdata),
        .i_req_tuser  (s_tuser),
        .i_req_tvalid (s_tvalid),
        .i_req_tready (s_tready),
        .i_res_tdata  (m_tdata),
        .i_res_tuser  (m_tuser),
        .i_res_tvalid (m_tvalid),
        .i_res_tready (m_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offer one request, after an optional idle burst, and hold it until taken
    task automatic send_request(input t_action act, input logic [SIZE_W-1:0] amt,
            input logic [ID_W-1:0] id);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {id, amt};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
    endtask

    // Result side: short random stalls, plus one long hold-off on request
    initial begin : result_sink
        int   stall_left;
        logic hold_taken;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // End the run when neither channel moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        t_action           act;
        logic [SIZE_W-1:0] amt;
        logic [ID_W-1:0]   id;
        int                pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // No blocks yet: allocate cannot fit, release finds nothing
        send_request(ACT_ALLOC, 16'd5, 8'd0);
        send_request(ACT_RELEASE, 16'd0, 8'hff);
        send_request(ACT_NOP, 16'hffff, 8'hff);
        // Smallest and largest blocks
        send_request(ACT_ADD, 16'd0, 8'd0);
        send_request(ACT_ADD, 16'hffff, 8'd0);
        // Zero request fits the empty block; reuse of a live id is refused
        send_request(ACT_ALLOC, 16'd0, 8'hff);
        send_request(ACT_ALLOC, 16'd1, 8'hff);
        // Largest request drains the big block, leaving nothing that fits
        send_request(ACT_ALLOC, 16'hffff, 8'd0);
        send_request(ACT_ALLOC, 16'd1, 8'd1);
        // Release, double release, zero-size release
        send_request(ACT_RELEASE, 16'd0, 8'd0);
        send_request(ACT_RELEASE, 16'd0, 8'd0);
        send_request(ACT_RELEASE, 16'hffff, 8'hff);
        // Fill the block table, then overflow it
        for (int i = 2; i < BLOCKS; i++)
            send_request(ACT_ADD, (i == 9) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(1, 4000)),
                         ID_W'($urandom));
        send_request(ACT_ADD, 16'hffff, 8'd0);

        // Random traffic, mostly allocate/release over a small owner pool
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n >= RANDOM_REQUESTS - QUIET_TAIL)
                idle_pct = 0;
            else if (n % 100 == 0)
                idle_pct = 15 * $urandom_range(0, 2);
            if (n == HOLD_OFF_AT)
                hold_off_req = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 4)
                act = ACT_NOP;
            else if (pick < 8)
                act = ACT_ADD;
            else if (pick < 52)
                act = ACT_ALLOC;
            else
                act = ACT_RELEASE;

            id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom)
                                             : ID_W'($urandom_range(0, ID_POOL - 1));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                amt = '0;
            else if (pick < 11)
                amt = SIZE_W'($urandom_range(1, 255));
            else if (pick < 17)
                amt = SIZE_W'($urandom_range(256, 4095));
            else
                amt = SIZE_W'($urandom);
            send_request(act, amt, id);
        end

        // Drain and give the verdict
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
